// ----- hdl/lppc_pkg.sv -----
// Shared constants, register codes and the gamma table for the LED panel packet composer.
// No dependencies; imported by the input channel interface and the top level.
`default_nettype none

package lppc_pkg;

  // Store geometry
  localparam int MAX_PIXELS = 32768;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);
  localparam int NUM_PANELS = 3;

  // Payload widths fixed by the channel definitions
  localparam int PIX_ADDR_W = 15;
  localparam int MAC_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Frame layout
  localparam int          FRAME_BYTES  = 1552;
  localparam int          HEADER_BYTES = 16;
  localparam logic [15:0] ETHERTYPE    = 16'h0801;
  localparam logic [7:0]  OPCODE       = 8'h29;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_MAC   = 3'd0,
    CFG_PANEL_MAC_0  = 3'd1,
    CFG_PANEL_MAC_1  = 3'd2,
    CFG_PANEL_MAC_2  = 3'd3,
    CFG_FRAME_WIDTH  = 3'd4,
    CFG_FRAME_HEIGHT = 3'd5
  } cfg_reg_t;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  // Gamma 1.5 table: largest k with 255*k*k <= v*v*v, built at elaboration
  typedef logic [255:0][7:0] gamma_lut_t;

  function automatic gamma_lut_t build_gamma();
    gamma_lut_t lut;
    int         cube;
    int         cnt;
    lut = '0;
    for (int v = 0; v < 256; v++) begin
      cube = v * v * v;
      cnt  = 0;
      for (int k = 1; k < 256; k++) begin
        if (255 * k * k <= cube) cnt = k;
      end
      lut[v] = 8'(cnt);
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage

`default_nettype wire

// ----- hdl/lppc_in_if.sv -----
// Input channel: valid/ready handshake carrying one pixel write or emit request per word.
// Depends on lppc_pkg for the address width.
`default_nettype none

interface lppc_in_if
  import lppc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [PIX_ADDR_W-1:0] pixel_address;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;

  modport source (output valid, output operation, output pixel_address,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input operation, input pixel_address,
                  input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- hdl/lppc_out_if.sv -----
// Result channel: valid/ready handshake carrying one frame byte per word.
// No dependencies.
`default_nettype none

interface lppc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_frame;

  modport source (output valid, output out_byte, output last_of_frame, input ready);
  modport sink   (input valid, input out_byte, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- hdl/led_panel_packet_composer.sv -----
// Top level of the LED panel packet composer: pixel store, frame sequencer, gamma output.
// Depends on lppc_pkg, lppc_in_if and lppc_out_if.
//
//   channel   dir  handshake       payload
//   in_chan   in   valid/ready     operation, pixel_address, red, green, blue
//   out_chan  out  valid/ready     out_byte, last_of_frame
//   cfg_*     in   cfg_we strobe   cfg_index, cfg_data (48 bits)
//
// One word is taken per cycle unless the output stalls with the read stage full. An emit
// word goes through the store read register, then the output register, to out_chan.
// The store address path (row times stride multiply plus column add) sets the cycle
// time. Pixel writes go straight to the store and produce no word. Synchronous
// active-low reset clears the counters and loads the register defaults; the store is
// not cleared. A stalled output holds one word in the output register and one in the
// read stage.
`default_nettype none

module led_panel_packet_composer
  import lppc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lppc_in_if.sink                    in_chan,
  lppc_out_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [MAC_W-1:0] source_mac_r;
  logic [MAC_W-1:0] panel_mac_r [3];
  logic [8:0]       frame_width_r;
  logic [7:0]       frame_height_r;

  // Frame position counters
  logic [10:0] byte_pos_r, byte_pos_nxt;
  logic [2:0]  chunk_r, chunk_nxt;
  logic [1:0]  panel_r, panel_nxt;
  logic [5:0]  col_r, col_nxt;
  logic [2:0]  row_r, row_nxt;
  logic [1:0]  comp_r, comp_nxt;

  // Pixel store
  logic [23:0] mem_r [MAX_PIXELS];
  logic [23:0] rd_r;

  // Read stage
  logic        s1_valid_r;
  logic        s1_hdr_r;
  logic [7:0]  s1_byte_r;
  logic [1:0]  s1_comp_r;
  logic        s1_inrange_r;
  logic        s1_last_r;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  // Handshake
  logic out_take;
  logic s1_move;
  logic in_fire;
  logic emit_fire;
  logic wr_fire;

  assign out_take  = !out_valid_r || out_chan.ready;
  assign s1_move   = s1_valid_r && out_take;
  assign in_chan.ready = !s1_valid_r || out_take;
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign emit_fire = in_fire && (in_chan.operation == OP_EMIT);
  assign wr_fire   = in_fire && (in_chan.operation == OP_WRITE) &&
                     (32'(in_chan.pixel_address) < 32'(MAX_PIXELS));

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = out_byte_r;
  assign out_chan.last_of_frame = out_last_r;

  // One header byte of a MAC address, most significant first
  function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      default: b = mac[7:0];
    endcase
    return b;
  endfunction

  // Header byte for the current position
  logic [7:0] hdr_byte;
  always_comb begin
    case (byte_pos_r[3:0])
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5:
        hdr_byte = mac_byte(panel_mac_r[panel_r], byte_pos_r[2:0]);
      4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11:
        hdr_byte = mac_byte(source_mac_r, 3'(byte_pos_r[3:0] - 4'd6));
      4'd12:   hdr_byte = ETHERTYPE[15:8];
      4'd13:   hdr_byte = ETHERTYPE[7:0];
      4'd14:   hdr_byte = OPCODE;
      default: hdr_byte = {5'd0, chunk_r};
    endcase
  end

  // Rotated store address: column width-1-(cx+x), row height-1-(p*32+cy+y)
  logic [6:0]  col_off;
  logic [6:0]  row_off;
  logic [10:0] fx;
  logic [9:0]  fy;
  logic [17:0] pix_idx;
  logic        in_range;

  always_comb begin
    col_off  = {chunk_r[2], col_r};
    row_off  = {panel_r, chunk_r[1:0], row_r};
    fx       = {2'b00, frame_width_r} - 11'd1 - {4'b0000, col_off};
    fy       = {2'b00, frame_height_r} - 10'd1 - {3'b000, row_off};
    pix_idx  = 18'(fy[8:0]) * 18'(frame_width_r) + 18'(fx[9:0]);
    in_range = !fx[10] && !fy[9] && (pix_idx < 18'(MAX_PIXELS));
  end

  // Position counters advance once per emit word
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    chunk_nxt    = chunk_r;
    panel_nxt    = panel_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    comp_nxt     = comp_r;
    if (emit_fire) begin
      if (byte_pos_r == 11'(FRAME_BYTES - 1)) begin
        byte_pos_nxt = '0;
        col_nxt      = '0;
        row_nxt      = '0;
        comp_nxt     = '0;
        if (chunk_r == 3'd7) begin
          chunk_nxt = '0;
          panel_nxt = (panel_r == 2'(NUM_PANELS - 1)) ? 2'd0 : panel_r + 2'd1;
        end else begin
          chunk_nxt = chunk_r + 3'd1;
        end
      end else begin
        byte_pos_nxt = byte_pos_r + 11'd1;
        if (byte_pos_r >= 11'(HEADER_BYTES)) begin
          if (comp_r == 2'd2) begin
            comp_nxt = '0;
            col_nxt  = col_r + 6'd1;
            if (col_r == 6'd63) row_nxt = row_r + 3'd1;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
    end
  end

  // Configuration and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_mac_r   <= '0;
      panel_mac_r[0] <= 48'hDEADBEEFC0D1;
      panel_mac_r[1] <= 48'hDEADBEEFC0D2;
      panel_mac_r[2] <= 48'hDEADBEEFC0D0;
      frame_width_r  <= 9'd128;
      frame_height_r <= 8'd96;
      byte_pos_r     <= '0;
      chunk_r        <= '0;
      panel_r        <= '0;
      col_r          <= '0;
      row_r          <= '0;
      comp_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SOURCE_MAC:   source_mac_r   <= cfg_data[MAC_W-1:0];
          CFG_PANEL_MAC_0:  panel_mac_r[0] <= cfg_data[MAC_W-1:0];
          CFG_PANEL_MAC_1:  panel_mac_r[1] <= cfg_data[MAC_W-1:0];
          CFG_PANEL_MAC_2:  panel_mac_r[2] <= cfg_data[MAC_W-1:0];
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[8:0];
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      byte_pos_r <= byte_pos_nxt;
      chunk_r    <= chunk_nxt;
      panel_r    <= panel_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      comp_r     <= comp_nxt;
    end
  end

  // Pixel store: writes at acceptance, emit reads at acceptance so order is kept
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[PIX_AW'(in_chan.pixel_address)] <= {in_chan.red, in_chan.green, in_chan.blue};
    end
    if (emit_fire) begin
      rd_r <= mem_r[pix_idx[PIX_AW-1:0]];
    end
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (emit_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      s1_hdr_r     <= (byte_pos_r < 11'(HEADER_BYTES));
      s1_byte_r    <= hdr_byte;
      s1_comp_r    <= comp_r;
      s1_inrange_r <= in_range;
      s1_last_r    <= (byte_pos_r == 11'(FRAME_BYTES - 1));
    end
  end

  // Colour component select and gamma
  logic [7:0] comp_val;
  logic [7:0] pix_byte;
  always_comb begin
    case (s1_comp_r)
      2'd0:    comp_val = rd_r[23:16];
      2'd1:    comp_val = rd_r[15:8];
      default: comp_val = rd_r[7:0];
    endcase
    if (!s1_inrange_r) comp_val = 8'd0;
    pix_byte = GAMMA_LUT[comp_val];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_byte_r <= s1_hdr_r ? s1_byte_r : pix_byte;
      out_last_r <= s1_last_r;
    end
  end

endmodule

`default_nettype wire
